/* design/segment_intersection_defines.svh */
// assertion macros used by the checker file of segment_intersection
// no dependencies; expects a clock i_clk and reset i_rst_n in scope
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH

// same-cycle implication, off while in reset
`define SI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("segment_intersection check failed");

// next-cycle implication, off while in reset
`define SI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("segment_intersection check failed");

// next-cycle implication that also runs through reset
`define SI_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("segment_intersection check failed");

`endif

/* design/si_pkg.sv */
// types, sizes and helpers for the segment intersection block
// no dependencies
`timescale 1ns / 1ps

package si_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int FIELD_W    = 16;
    localparam int OUT_W      = 24;
    // internal coordinate: one bit more than a field
    localparam int CW         = FIELD_W + 1;
    localparam int DW         = CW + 1;
    localparam int PW         = 2 * DW;
    localparam int DENW       = PW + 1;
    localparam int PRODW      = DENW + DW;
    localparam int QW         = DW - 1 + FRAC_BITS;
    localparam int MAGW       = DENW + DW + FRAC_BITS - 2;
    localparam int SUMW       = MAGW + 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic signed [FIELD_W-1:0] a_start_x;
        logic signed [FIELD_W-1:0] a_start_y;
        logic signed [FIELD_W-1:0] a_end_x;
        logic signed [FIELD_W-1:0] a_end_y;
        logic signed [FIELD_W-1:0] b_start_x;
        logic signed [FIELD_W-1:0] b_start_y;
        logic signed [FIELD_W-1:0] b_end_x;
        logic signed [FIELD_W-1:0] b_end_y;
    } t_seg_in;

    typedef struct packed {
        logic                    hit;
        logic signed [OUT_W-1:0] cross_x;
        logic signed [OUT_W-1:0] cross_y;
    } t_seg_out;

    // classified pair handed from front to back
    typedef struct packed {
        logic                   hit;
        logic signed [DENW-1:0] na;
        logic signed [DENW-1:0] den;
        logic signed [DW-1:0]   dax;
        logic signed [DW-1:0]   day;
        logic signed [CW-1:0]   ax0;
        logic signed [CW-1:0]   ay0;
    } t_job;

    // side data riding along the divider
    typedef struct packed {
        logic                 hit;
        logic                 negx;
        logic                 negy;
        logic signed [CW-1:0] ax0;
        logic signed [CW-1:0] ay0;
    } t_aux;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic logic signed [CW-1:0] coord_of(logic [FIELD_W-1:0] raw);
        logic [CW-1:0] v;
        v = '0;
        for (int i = 0; i < FIELD_W; i++) begin
            if (i < COORD_BITS) v[i] = raw[i];
        end
        if (COORD_BITS <= FIELD_W) begin
            for (int i = 0; i < CW; i++) begin
                if (i >= COORD_BITS) v[i] = raw[(COORD_BITS <= FIELD_W) ? COORD_BITS - 1 : 0];
            end
        end
        return signed'(v);
    endfunction

    function automatic logic in_unit(logic signed [DENW-1:0] num, logic signed [DENW-1:0] den);
        logic r;
        if (!den[DENW-1]) r = !num[DENW-1] && (num <= den);
        else r = (num[DENW-1] || num == '0) && (num >= den);
        return r;
    endfunction

endpackage

/* design/segment_intersection.sv */
// segment intersection: top level joining front, queue and back
// depends on si_pkg, si_front, si_fifo, si_back
//
// use of the block
//   input channel: i_valid / o_stall carry one beat per segment pair in
//   i_item; a beat is taken at a clock edge with i_valid high and o_stall low
//   output channel: o_valid / i_stall carry one result beat in o_result
//   (hit flag and the crossing point with FRAC_BITS fraction bits)
//   throughput: one pair per cycle while the receiver does not stall, set by
//   the fully pipelined divider; pipeline: two front stages, the queue,
//   one multiply stage, QW+1 divider stages, the output register
//   a receiver stall freezes the whole back pipeline; the four-entry queue
//   then fills while the front keeps taking beats, and o_stall rises only
//   once the queue is full and the front has a beat it cannot hand on
//   reset (synchronous, active low) empties every stage and the queue; no
//   result beat is lost or repeated across a stall
//   no hit, a zero-length segment or parallel segments give hit low and a
//   zero point
`timescale 1ns / 1ps

module segment_intersection (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  si_pkg::t_seg_in  i_item,
    output logic             o_valid,
    input  logic             i_stall,
    output si_pkg::t_seg_out o_result
);

    // front to queue
    logic               w_push;
    si_pkg::t_job       w_push_job;
    // queue to back
    logic               w_pop;
    si_pkg::t_job       w_head_job;
    si_pkg::t_fifo_stat w_stat;

    si_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_push  (w_push),
        .o_job   (w_push_job),
        .i_full  (w_stat.full)
    );

    si_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_stat)
    );

    si_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_head_job),
        .i_stat   (w_stat),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule

/* design/si_front.sv */
// front: difference, cross products and classification of a segment pair
// depends on si_pkg
`timescale 1ns / 1ps

module si_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  si_pkg::t_seg_in i_item,
    output logic            o_push,
    output si_pkg::t_job    o_job,
    input  logic            i_full
);

    logic r_a_valid, n_a_valid, r_b_valid, n_b_valid, w_en;
    logic signed [si_pkg::PW-1:0] r_p_dd1, r_p_dd2, r_p_na1, r_p_na2, r_p_nb1, r_p_nb2;
    logic signed [si_pkg::DW-1:0] r_dax, r_day;
    logic signed [si_pkg::CW-1:0] r_ax0, r_ay0;
    logic r_zero_len;
    si_pkg::t_job r_job;

    logic signed [si_pkg::CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic signed [si_pkg::DW-1:0] dax, day, dbx, dby, wx, wy;
    logic signed [si_pkg::DENW-1:0] den, na, nb;

    assign w_en    = !(r_b_valid && i_full);
    assign o_stall = !w_en;
    assign o_push  = r_b_valid && !i_full;
    assign o_job   = r_job;

    always_comb begin
        ax0 = si_pkg::coord_of(i_item.a_start_x);
        ay0 = si_pkg::coord_of(i_item.a_start_y);
        ax1 = si_pkg::coord_of(i_item.a_end_x);
        ay1 = si_pkg::coord_of(i_item.a_end_y);
        bx0 = si_pkg::coord_of(i_item.b_start_x);
        by0 = si_pkg::coord_of(i_item.b_start_y);
        bx1 = si_pkg::coord_of(i_item.b_end_x);
        by1 = si_pkg::coord_of(i_item.b_end_y);
        dax = si_pkg::DW'(ax1) - si_pkg::DW'(ax0);
        day = si_pkg::DW'(ay1) - si_pkg::DW'(ay0);
        dbx = si_pkg::DW'(bx1) - si_pkg::DW'(bx0);
        dby = si_pkg::DW'(by1) - si_pkg::DW'(by0);
        wx  = si_pkg::DW'(ax0) - si_pkg::DW'(bx0);
        wy  = si_pkg::DW'(ay0) - si_pkg::DW'(by0);
        den = si_pkg::DENW'(r_p_dd1) - si_pkg::DENW'(r_p_dd2);
        na  = si_pkg::DENW'(r_p_na1) - si_pkg::DENW'(r_p_na2);
        nb  = si_pkg::DENW'(r_p_nb1) - si_pkg::DENW'(r_p_nb2);
        n_a_valid = w_en ? i_valid : r_a_valid;
        n_b_valid = w_en ? r_a_valid : r_b_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_dd1    <= si_pkg::PW'(dby) * si_pkg::PW'(dax);
            r_p_dd2    <= si_pkg::PW'(dbx) * si_pkg::PW'(day);
            r_p_na1    <= si_pkg::PW'(dbx) * si_pkg::PW'(wy);
            r_p_na2    <= si_pkg::PW'(dby) * si_pkg::PW'(wx);
            r_p_nb1    <= si_pkg::PW'(dax) * si_pkg::PW'(wy);
            r_p_nb2    <= si_pkg::PW'(day) * si_pkg::PW'(wx);
            r_dax      <= dax;
            r_day      <= day;
            r_ax0      <= ax0;
            r_ay0      <= ay0;
            r_zero_len <= (dax == '0 && day == '0) || (dbx == '0 && dby == '0);
            r_job.hit  <= !r_zero_len && den != '0 && si_pkg::in_unit(na, den)
                          && si_pkg::in_unit(nb, den);
            r_job.na   <= na;
            r_job.den  <= den;
            r_job.dax  <= r_dax;
            r_job.day  <= r_day;
            r_job.ax0  <= r_ax0;
            r_job.ay0  <= r_ay0;
        end
    end

endmodule

/* design/si_fifo.sv */
// short queue of classified pairs between front and back
// depends on si_pkg
`timescale 1ns / 1ps

module si_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  si_pkg::t_job       i_job,
    input  logic               i_pop,
    output si_pkg::t_job       o_job,
    output si_pkg::t_fifo_stat o_stat
);

    si_pkg::t_job r_mem [si_pkg::FIFO_DEPTH];
    logic [si_pkg::FIFO_AW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [si_pkg::FIFO_AW:0]   r_cnt, n_cnt;
    logic w_push, w_pop;

    assign o_stat.full  = r_cnt == (si_pkg::FIFO_AW+1)'(si_pkg::FIFO_DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign o_job        = r_mem[r_rd];

    always_comb begin
        w_push = i_push && !o_stat.full;
        w_pop  = i_pop && !o_stat.empty;
        n_wr   = w_push ? r_wr + 1'b1 : r_wr;
        n_rd   = w_pop ? r_rd + 1'b1 : r_rd;
        n_cnt  = r_cnt + (si_pkg::FIFO_AW+1)'(w_push) - (si_pkg::FIFO_AW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_job;
    end

endmodule

/* design/si_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on si_pkg
`timescale 1ns / 1ps

module si_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [si_pkg::MAGW-1:0]   i_num,
    input  logic [si_pkg::DENW-1:0]   i_den,
    output logic [si_pkg::QW-1:0]     o_quo
);

    logic [si_pkg::MAGW-1:0] r_rem [si_pkg::QW+1];
    logic [si_pkg::DENW-1:0] r_den [si_pkg::QW+1];
    logic [si_pkg::QW-1:0]   r_quo [si_pkg::QW+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    for (genvar g = 0; g < si_pkg::QW; g++) begin : g_stage
        logic [si_pkg::MAGW-1:0] w_sh;
        logic                    w_ge;
        assign w_sh = si_pkg::MAGW'(r_den[g]) << (si_pkg::QW - 1 - g);
        assign w_ge = r_rem[g] >= w_sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= w_ge ? r_rem[g] - w_sh : r_rem[g];
                r_den[g+1] <= r_den[g];
                r_quo[g+1] <= r_quo[g] | (si_pkg::QW'(w_ge) << (si_pkg::QW - 1 - g));
            end
        end
    end

    assign o_quo = r_quo[si_pkg::QW];

endmodule

/* design/si_back.sv */
// back: scale products, divide by the denominator and form the point
// depends on si_pkg, si_div
`timescale 1ns / 1ps

module si_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  si_pkg::t_job       i_job,
    input  si_pkg::t_fifo_stat i_stat,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output si_pkg::t_seg_out   o_result
);

    localparam int NST = si_pkg::QW + 2;

    logic w_en;
    logic r_valid [NST];
    logic r_out_valid;
    si_pkg::t_seg_out r_out, n_out;
    si_pkg::t_job r_job;
    logic signed [si_pkg::PRODW-1:0] r_px, r_py;
    si_pkg::t_aux r_aux [1:NST-1];
    si_pkg::t_aux w_aux;
    logic [si_pkg::PRODW-1:0] w_mx, w_my;
    logic [si_pkg::DENW-1:0]  w_mden;
    logic [si_pkg::MAGW-1:0]  w_numx, w_numy;
    logic [si_pkg::QW-1:0]    w_qx, w_qy;
    logic signed [si_pkg::SUMW-1:0] w_cx, w_cy, w_sqx, w_sqy;
    si_pkg::t_aux w_last;

    assign w_en     = !(r_out_valid && i_stall);
    assign o_pop    = w_en;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        w_mx   = r_px[si_pkg::PRODW-1] ? unsigned'(-r_px) : unsigned'(r_px);
        w_my   = r_py[si_pkg::PRODW-1] ? unsigned'(-r_py) : unsigned'(r_py);
        w_mden = r_job.den[si_pkg::DENW-1] ? unsigned'(-r_job.den) : unsigned'(r_job.den);
        w_numx = si_pkg::MAGW'(w_mx) << si_pkg::FRAC_BITS;
        w_numy = si_pkg::MAGW'(w_my) << si_pkg::FRAC_BITS;
        w_aux.hit  = r_job.hit;
        w_aux.negx = r_px[si_pkg::PRODW-1] ^ r_job.den[si_pkg::DENW-1];
        w_aux.negy = r_py[si_pkg::PRODW-1] ^ r_job.den[si_pkg::DENW-1];
        w_aux.ax0  = r_job.ax0;
        w_aux.ay0  = r_job.ay0;
    end

    si_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_numx),
        .i_den (w_mden),
        .o_quo (w_qx)
    );

    si_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_numy),
        .i_den (w_mden),
        .o_quo (w_qy)
    );

    always_comb begin
        w_last = r_aux[NST-1];
        w_sqx  = w_last.negx ? -signed'(si_pkg::SUMW'(w_qx)) : signed'(si_pkg::SUMW'(w_qx));
        w_sqy  = w_last.negy ? -signed'(si_pkg::SUMW'(w_qy)) : signed'(si_pkg::SUMW'(w_qy));
        w_cx   = (si_pkg::SUMW'(w_last.ax0) <<< si_pkg::FRAC_BITS) + w_sqx;
        w_cy   = (si_pkg::SUMW'(w_last.ay0) <<< si_pkg::FRAC_BITS) + w_sqy;
        n_out.hit     = w_last.hit;
        n_out.cross_x = w_last.hit ? w_cx[si_pkg::OUT_W-1:0] : '0;
        n_out.cross_y = w_last.hit ? w_cy[si_pkg::OUT_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) r_valid[i] <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_valid[0] <= !i_stat.empty;
            for (int i = 1; i < NST; i++) r_valid[i] <= r_valid[i-1];
            r_out_valid <= r_valid[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_job  <= i_job;
            r_px   <= si_pkg::PRODW'(i_job.na) * si_pkg::PRODW'(i_job.dax);
            r_py   <= si_pkg::PRODW'(i_job.na) * si_pkg::PRODW'(i_job.day);
            r_aux[1] <= w_aux;
            for (int i = 2; i < NST; i++) r_aux[i] <= r_aux[i-1];
            r_out  <= n_out;
        end
    end

endmodule

/* design/si_checker.sv */
// port-level checks for segment_intersection, bound to the top level
// depends on si_pkg and segment_intersection_defines.svh
`timescale 1ns / 1ps
`include "segment_intersection_defines.svh"

module si_port_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input si_pkg::t_seg_out o_result
);

    // a stalled result beat stays put
    `SI_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_result))
    // no hit means a zero point
    `SI_ASSERT_IMPL(a_miss_zero, o_valid && !o_result.hit, {o_result.cross_x, o_result.cross_y} == '0)
    // reset leaves the block empty and ready
    `SI_ASSERT_RST(a_reset_empty, !i_rst_n, !o_valid && !o_stall)

endmodule

bind segment_intersection si_port_checker u_si_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_result (o_result)
);
